// File: sv/quadratic_root_solver_core_assert.svh
// Assertion macros used by the quadratic root solver queue.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define QRS_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition");
`else
`define QRS_ASSERT_IMPL(label, clk, rst, prop)
`define QRS_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: sv/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;
   localparam int FracBitsDefault = 16;
   localparam int CoefW = 16;
   localparam int RootW = 32;
   localparam int DiscW = 35;
   localparam int MagW = 34;
   localparam int SqrtW = 42;
   localparam int SqrtSteps = 42;
   localparam int NumW = 44;
   localparam int DenW = 17;
   localparam int QuoW = 44;
   localparam int QueueDepth = 4;

   typedef struct packed {
      logic                  lead_zero;
      logic                  is_complex;
      logic signed [DenW-1:0] den;
      logic signed [CoefW-1:0] coef_b;
      logic [MagW-1:0]       mag;
   } front_item_type;
endpackage

// File: sv/qrs_front.sv
// Front end: accepts coefficients and forms the discriminant and its class.
`timescale 1ns / 1ps
module qrs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [qrs_pkg::CoefW-1:0]    req_coef_a,
   input  logic signed [qrs_pkg::CoefW-1:0]    req_coef_b,
   input  logic signed [qrs_pkg::CoefW-1:0]    req_coef_c,
   output logic                                fe_valid,
   input  logic                                fe_stall,
   output qrs_pkg::front_item_type             fe_item
);
   logic                    s1_valid_ff;
   logic signed [31:0]      bb_ff;
   logic signed [31:0]      ac_ff;
   logic signed [qrs_pkg::CoefW-1:0] a_ff, b_ff;
   logic                    s2_valid_ff;
   qrs_pkg::front_item_type item_ff;
   qrs_pkg::front_item_type item_in;
   logic signed [qrs_pkg::DiscW-1:0] disc;
   logic                    adv1, adv2;

   assign adv2 = !s2_valid_ff || !fe_stall;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   always_comb begin
      disc = qrs_pkg::DiscW'(bb_ff) - (qrs_pkg::DiscW'(ac_ff) <<< 2);
      item_in.lead_zero = (a_ff == '0);
      item_in.is_complex = disc[qrs_pkg::DiscW-1];
      item_in.den = qrs_pkg::DenW'(a_ff) <<< 1;
      item_in.coef_b = b_ff;
      item_in.mag = disc[qrs_pkg::DiscW-1] ? qrs_pkg::MagW'(-disc) : qrs_pkg::MagW'(disc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
      end
      if (adv1 && req_valid) begin
         bb_ff <= 32'(req_coef_b) * 32'(req_coef_b);
         ac_ff <= 32'(req_coef_a) * 32'(req_coef_c);
         a_ff <= req_coef_a;
         b_ff <= req_coef_b;
      end
      if (adv2 && s1_valid_ff) item_ff <= item_in;
   end

   assign fe_valid = s2_valid_ff;
   assign fe_item = item_ff;
endmodule

// File: sv/qrs_queue.sv
// Short queue between the front end and the solving back end.
`timescale 1ns / 1ps
`include "quadratic_root_solver_core_assert.svh"
module qrs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_valid,
   output logic                    wr_stall,
   input  qrs_pkg::front_item_type wr_item,
   output logic                    rd_valid,
   input  logic                    rd_stall,
   output qrs_pkg::front_item_type rd_item
);
   localparam int AW = $clog2(qrs_pkg::QueueDepth);
   qrs_pkg::front_item_type mem_ff [qrs_pkg::QueueDepth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic wr, rd;

   assign wr_stall = (cnt_ff == (AW+1)'(qrs_pkg::QueueDepth));
   assign rd_valid = (cnt_ff != '0);
   assign wr = wr_valid && !wr_stall;
   assign rd = rd_valid && !rd_stall;
   assign rd_item = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
      if (wr) mem_ff[wp_ff] <= wr_item;
   end

   `QRS_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > (AW+1)'(qrs_pkg::QueueDepth))
   `QRS_ASSERT_IMPL(a_cnt_inc, clock, reset, (wr && !rd) |=> cnt_ff == $past(cnt_ff) + 1'b1)
   `QRS_ASSERT_IMPL(a_cnt_dec, clock, reset, (rd && !wr) |=> cnt_ff == $past(cnt_ff) - 1'b1)
endmodule

// File: sv/qrs_back.sv
// Back end: pipelined square root, four pipelined dividers and saturation.
`timescale 1ns / 1ps
module qrs_back #(
   parameter int FRAC_BITS = qrs_pkg::FracBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_stall,
   input  qrs_pkg::front_item_type           in_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [qrs_pkg::RootW-1:0]  rsp_root0_real,
   output logic signed [qrs_pkg::RootW-1:0]  rsp_root0_imag,
   output logic signed [qrs_pkg::RootW-1:0]  rsp_root1_real,
   output logic signed [qrs_pkg::RootW-1:0]  rsp_root1_imag,
   output logic                              rsp_lead_zero_error,
   output logic                              rsp_saturated
);
   localparam int SW = qrs_pkg::SqrtW;
   localparam int NS = qrs_pkg::SqrtSteps;
   localparam int RW = SW + 2;
   localparam int XW = 2 * SW;
   localparam int NW = qrs_pkg::NumW;
   localparam int QW = qrs_pkg::QuoW;
   localparam int DW = qrs_pkg::DenW;
   localparam int ND = QW;
   localparam int AW = DW;

   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign in_stall = !adv;

   // Square root pipeline, one result bit per stage.
   logic          sv_ff   [NS+1];
   logic [XW-1:0] sx_ff   [NS+1];
   logic [SW-1:0] sr_ff   [NS+1];
   logic [RW-1:0] srem_ff [NS+1];
   qrs_pkg::front_item_type sit_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else if (adv) sv_ff[0] <= in_valid;
      if (adv) begin
         sx_ff[0] <= XW'(in_item.mag) << (2 * FRAC_BITS);
         sr_ff[0] <= '0;
         srem_ff[0] <= '0;
         sit_ff[0] <= in_item;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      logic [RW-1:0] rem_sh, trial;
      always_comb begin
         rem_sh = {srem_ff[i][RW-3:0], sx_ff[i][XW-1:XW-2]};
         trial = {sr_ff[i], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) sv_ff[i+1] <= 1'b0;
         else if (adv) sv_ff[i+1] <= sv_ff[i];
         if (adv) begin
            sx_ff[i+1] <= sx_ff[i] << 2;
            sit_ff[i+1] <= sit_ff[i];
            if (rem_sh >= trial) begin
               srem_ff[i+1] <= rem_sh - trial;
               sr_ff[i+1] <= {sr_ff[i][SW-2:0], 1'b1};
            end else begin
               srem_ff[i+1] <= rem_sh;
               sr_ff[i+1] <= {sr_ff[i][SW-2:0], 1'b0};
            end
         end
      end
   end

   // Numerator setup: four signed numerators, magnitudes and signs.
   logic signed [NW-1:0] bs, s_sg;
   logic signed [NW-1:0] n_in [4];
   logic          pv_ff;
   logic [NW-1:0] pm_ff [4];
   logic          pn_ff [4];
   logic [AW-1:0] pd_ff;
   logic          plz_ff;
   qrs_pkg::front_item_type ti;

   always_comb begin
      ti = sit_ff[NS];
      bs = NW'(ti.coef_b) <<< FRAC_BITS;
      s_sg = NW'(sr_ff[NS]);
      if (ti.is_complex) begin
         n_in[0] = -bs;
         n_in[1] = s_sg;
         n_in[2] = -bs;
         n_in[3] = -s_sg;
      end else begin
         n_in[0] = -bs + s_sg;
         n_in[1] = '0;
         n_in[2] = -bs - s_sg;
         n_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else if (adv) pv_ff <= sv_ff[NS];
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            pm_ff[k] <= n_in[k][NW-1] ? NW'(-n_in[k]) : NW'(n_in[k]);
            pn_ff[k] <= n_in[k][NW-1] ^ ti.den[DW-1];
         end
         pd_ff <= ti.den[DW-1] ? AW'(-ti.den) : AW'(ti.den);
         plz_ff <= ti.lead_zero;
      end
   end

   // Restoring dividers, one quotient bit per stage.
   logic          dv_ff  [ND+1];
   logic [NW-1:0] dn_ff  [ND+1][4];
   logic [AW:0]   dr_ff  [ND+1][4];
   logic [QW-1:0] dq_ff  [ND+1][4];
   logic          dg_ff  [ND+1][4];
   logic [AW-1:0] dd_ff  [ND+1];
   logic          dlz_ff [ND+1];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (adv) dv_ff[0] <= pv_ff;
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            dn_ff[0][k] <= pm_ff[k];
            dr_ff[0][k] <= '0;
            dq_ff[0][k] <= '0;
            dg_ff[0][k] <= pn_ff[k];
         end
         dd_ff[0] <= pd_ff;
         dlz_ff[0] <= plz_ff;
      end
   end

   for (genvar j = 0; j < ND; j++) begin : g_div
      for (genvar k = 0; k < 4; k++) begin : g_lane
         logic [AW+1:0] rs;
         assign rs = {dr_ff[j][k], dn_ff[j][k][NW-1]};
         always_ff @(posedge clock) begin
            if (adv) begin
               dn_ff[j+1][k] <= dn_ff[j][k] << 1;
               dg_ff[j+1][k] <= dg_ff[j][k];
               if (rs >= (AW+2)'(dd_ff[j])) begin
                  dr_ff[j+1][k] <= (AW+1)'(rs - (AW+2)'(dd_ff[j]));
                  dq_ff[j+1][k] <= {dq_ff[j][k][QW-2:0], 1'b1};
               end else begin
                  dr_ff[j+1][k] <= (AW+1)'(rs);
                  dq_ff[j+1][k] <= {dq_ff[j][k][QW-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[j+1] <= 1'b0;
         else if (adv) dv_ff[j+1] <= dv_ff[j];
         if (adv) begin
            dd_ff[j+1] <= dd_ff[j];
            dlz_ff[j+1] <= dlz_ff[j];
         end
      end
   end

   // Saturation and output register.
   logic [qrs_pkg::RootW-1:0] r_in [4];
   logic [3:0] sat_in;
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (dg_ff[ND][k]) begin
            if (dq_ff[ND][k] > QW'(64'h8000_0000)) begin
               r_in[k] = 32'h8000_0000;
               sat_in[k] = 1'b1;
            end else begin
               r_in[k] = 32'(-dq_ff[ND][k]);
               sat_in[k] = 1'b0;
            end
         end else begin
            if (dq_ff[ND][k] > QW'(64'h7FFF_FFFF)) begin
               r_in[k] = 32'h7FFF_FFFF;
               sat_in[k] = 1'b1;
            end else begin
               r_in[k] = 32'(dq_ff[ND][k]);
               sat_in[k] = 1'b0;
            end
         end
         if (dlz_ff[ND]) begin
            r_in[k] = '0;
            sat_in[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= dv_ff[ND];
      if (adv) begin
         rsp_root0_real <= r_in[0];
         rsp_root0_imag <= r_in[1];
         rsp_root1_real <= r_in[2];
         rsp_root1_imag <= r_in[3];
         rsp_lead_zero_error <= dlz_ff[ND];
         rsp_saturated <= |sat_in;
      end
   end
endmodule

// File: sv/quadratic_root_solver_core.sv
// Top level of the quadratic root solver.
`timescale 1ns / 1ps
// Solves a*x^2+b*x+c for one coefficient set per clock cycle while
// req_stall is low. A two-stage front end forms the discriminant and
// classifies it, a four-entry queue decouples it from the back end, and
// the back end runs a 42-stage square root pipeline and four 44-stage
// division pipelines in lockstep. A stalled result holds the whole back
// end, which the queue absorbs until it is full.
module quadratic_root_solver_core #(
   parameter int FRAC_BITS = qrs_pkg::FracBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [qrs_pkg::CoefW-1:0]  req_coef_a,
   input  logic signed [qrs_pkg::CoefW-1:0]  req_coef_b,
   input  logic signed [qrs_pkg::CoefW-1:0]  req_coef_c,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [qrs_pkg::RootW-1:0]  rsp_root0_real,
   output logic signed [qrs_pkg::RootW-1:0]  rsp_root0_imag,
   output logic signed [qrs_pkg::RootW-1:0]  rsp_root1_real,
   output logic signed [qrs_pkg::RootW-1:0]  rsp_root1_imag,
   output logic                              rsp_lead_zero_error,
   output logic                              rsp_saturated
);
   logic fe_valid, fe_stall, bq_valid, bq_stall;
   qrs_pkg::front_item_type fe_item, bq_item;

   qrs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_coef_a, .req_coef_b,
      .req_coef_c, .fe_valid, .fe_stall, .fe_item
   );

   qrs_queue u_queue (
      .clock, .reset, .wr_valid(fe_valid), .wr_stall(fe_stall), .wr_item(fe_item),
      .rd_valid(bq_valid), .rd_stall(bq_stall), .rd_item(bq_item)
   );

   qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .in_valid(bq_valid), .in_stall(bq_stall), .in_item(bq_item),
      .rsp_valid, .rsp_stall, .rsp_root0_real, .rsp_root0_imag, .rsp_root1_real,
      .rsp_root1_imag, .rsp_lead_zero_error, .rsp_saturated
   );
endmodule

// File: sim/tb_quadratic_root_solver_core.sv
// Self-checking testbench for the quadratic root solver core.
`timescale 1ns / 1ps
module tb_quadratic_root_solver_core;
   localparam int FracBits = 16;
   localparam int NumRandom = 1550;
   localparam int DrainCycles = 200;

   typedef struct packed {
      logic signed [qrs_pkg::RootW-1:0] r0re;
      logic signed [qrs_pkg::RootW-1:0] r0im;
      logic signed [qrs_pkg::RootW-1:0] r1re;
      logic signed [qrs_pkg::RootW-1:0] r1im;
      logic                             lz;
      logic                             sat;
   } roots_type;

   typedef struct {
      logic signed [qrs_pkg::CoefW-1:0] a;
      logic signed [qrs_pkg::CoefW-1:0] b;
      logic signed [qrs_pkg::CoefW-1:0] c;
      logic                             typed;
      roots_type                        want;
   } coef_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [qrs_pkg::CoefW-1:0] req_coef_a = '0;
   logic signed [qrs_pkg::CoefW-1:0] req_coef_b = '0;
   logic signed [qrs_pkg::CoefW-1:0] req_coef_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [qrs_pkg::RootW-1:0] rsp_root0_real, rsp_root0_imag;
   logic signed [qrs_pkg::RootW-1:0] rsp_root1_real, rsp_root1_imag;
   logic rsp_lead_zero_error, rsp_saturated;

   roots_type pending_roots[$];
   coef_row_type coef_table[$];
   int errors = 0;
   bit quiet_phase = 1'b0;

   quadratic_root_solver_core #(.FRAC_BITS(FracBits)) uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] scaled_sqrt(logic [63:0] mag);
      logic [127:0] x;
      logic [127:0] root;
      logic [127:0] rem;
      logic [127:0] trial;
      x = {64'd0, mag} << (2 * FracBits);
      root = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | ((x >> (2 * i)) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic logic signed [qrs_pkg::RootW-1:0] clamped_quot(longint num,
                                                                   longint den,
                                                                   ref logic sat);
      longint q;
      q = num / den;
      if (q > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (q < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return q[31:0];
   endfunction

   function automatic roots_type solve_roots(logic signed [qrs_pkg::CoefW-1:0] a,
                                            logic signed [qrs_pkg::CoefW-1:0] b,
                                            logic signed [qrs_pkg::CoefW-1:0] c);
      roots_type r;
      longint la, lb, lc, disc, den, bs, s;
      logic sat;
      r = '{default: '0};
      sat = 1'b0;
      la = longint'(a);
      lb = longint'(b);
      lc = longint'(c);
      if (la == 0) begin
         r.lz = 1'b1;
         return r;
      end
      disc = lb * lb - 4 * la * lc;
      den = 2 * la;
      bs = lb * (64'sd1 <<< FracBits);
      if (disc >= 0) begin
         s = scaled_sqrt(disc);
         r.r0re = clamped_quot(-bs + s, den, sat);
         r.r1re = clamped_quot(-bs - s, den, sat);
      end else begin
         s = scaled_sqrt(-disc);
         r.r0re = clamped_quot(-bs, den, sat);
         r.r1re = r.r0re;
         r.r0im = clamped_quot(s, den, sat);
         r.r1im = clamped_quot(-s, den, sat);
      end
      r.sat = sat;
      return r;
   endfunction

   function automatic int idle_chance();
      return quiet_phase ? 0 : 34;
   endfunction

   task automatic add_row(int a, int b, int c, bit typed, roots_type want);
      coef_row_type row;
      row.a = qrs_pkg::CoefW'(a);
      row.b = qrs_pkg::CoefW'(b);
      row.c = qrs_pkg::CoefW'(c);
      row.typed = typed;
      row.want = want;
      coef_table.push_back(row);
   endtask

   task automatic send_coefs(logic signed [qrs_pkg::CoefW-1:0] a,
                             logic signed [qrs_pkg::CoefW-1:0] b,
                             logic signed [qrs_pkg::CoefW-1:0] c, roots_type want);
      while ($urandom_range(99) < idle_chance()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      pending_roots.push_back(want);
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < idle_chance());
      end
   end

   always @(posedge clock) begin
      roots_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_roots.size() == 0) begin
            $display("%0t: unexpected result", $time);
            errors++;
         end else begin
            want = pending_roots.pop_front();
            if (rsp_root0_real !== want.r0re || rsp_root0_imag !== want.r0im ||
                rsp_root1_real !== want.r1re || rsp_root1_imag !== want.r1im ||
                rsp_lead_zero_error !== want.lz || rsp_saturated !== want.sat) begin
               $display("%0t: expected %0d %0d %0d %0d lz=%0b sat=%0b", $time,
                        want.r0re, want.r0im, want.r1re, want.r1im, want.lz, want.sat);
               $display("%0t: actual   %0d %0d %0d %0d lz=%0b sat=%0b", $time,
                        rsp_root0_real, rsp_root0_imag, rsp_root1_real,
                        rsp_root1_imag, rsp_lead_zero_error, rsp_saturated);
               errors++;
            end
         end
      end
   end

   initial begin
      roots_type none;
      roots_type want;
      int wait_cycles;
      none = '{default: '0};
      want = none;
      want.lz = 1'b1;
      add_row(0, 0, 0, 1, want);
      add_row(0, -32768, 32767, 1, want);
      add_row(0, 32767, -32768, 1, want);
      want = none;
      add_row(1, 0, 0, 1, want);
      want.r0re = 32'sh00010000;
      want.r1re = 32'shffff0000;
      add_row(1, 0, -1, 1, want);
      want = none;
      want.r0im = 32'sh00010000;
      want.r1im = 32'shffff0000;
      add_row(1, 0, 1, 1, want);
      add_row(1, -32768, 0, 0, none);
      add_row(1, 32767, 0, 0, none);
      add_row(1, 0, -32768, 0, none);
      add_row(1, 0, 32767, 0, none);
      add_row(-1, 32767, 32767, 0, none);
      add_row(-32768, -32768, -32768, 0, none);
      add_row(32767, 32767, 32767, 0, none);
      add_row(-32768, 32767, -32768, 0, none);
      add_row(32767, -32768, 32767, 0, none);
      add_row(1, -32768, -32768, 0, none);
      add_row(-1, -32768, 32767, 0, none);
      add_row(1, 2, 1, 0, none);
      add_row(3, -7, 2, 0, none);
      add_row(-5, 1, -9, 0, none);
      add_row(2, 1, 32767, 0, none);
      add_row(-21846, 21845, -1, 0, none);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (coef_table[i]) begin
         want = solve_roots(coef_table[i].a, coef_table[i].b, coef_table[i].c);
         if (coef_table[i].typed && want != coef_table[i].want) begin
            $display("%0t: table row %0d disagrees with predictor", $time, i);
            errors++;
         end
         send_coefs(coef_table[i].a, coef_table[i].b, coef_table[i].c,
                    coef_table[i].typed ? coef_table[i].want : want);
      end
      for (int n = 0; n < NumRandom; n++) begin
         logic signed [qrs_pkg::CoefW-1:0] a, b, c;
         quiet_phase = (n >= 600 && n < 800);
         a = qrs_pkg::CoefW'($urandom);
         b = qrs_pkg::CoefW'($urandom);
         c = qrs_pkg::CoefW'($urandom);
         case ($urandom_range(7))
            0: a = '0;
            1: a = qrs_pkg::CoefW'($urandom_range(8) - 4);
            2: b = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            3: c = qrs_pkg::CoefW'($urandom_range(64) - 32);
            default: ;
         endcase
         send_coefs(a, b, c, solve_roots(a, b, c));
      end
      req_valid <= 1'b0;
      quiet_phase = 1'b0;
      wait_cycles = 0;
      while (pending_roots.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0 && pending_roots.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
